// ===== rtl/core/cqs_pkg.sv =====
// cqs_pkg: shared constants, types and helper functions for the circular queue with search.
// No dependencies. Compile first.
`default_nettype none

package cqs_pkg;

    localparam int DEPTH       = 128;
    localparam int WORD_BITS   = 32;
    localparam int IDX_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int CFG_BITS    = 8;
    localparam int ACT_BITS    = 2;
    localparam int STAT_BITS   = 2;
    localparam int CAP_DEFAULT = 100;
    localparam int CAP_RESET_INT = (CAP_DEFAULT > DEPTH) ? DEPTH : CAP_DEFAULT;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    localparam cnt_t CAP_RESET = cnt_t'(CAP_RESET_INT);

    localparam logic [ACT_BITS-1:0] ACT_ENQ  = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_DEQ  = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_SRCH = 2'd2;

    localparam logic [STAT_BITS-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_SRCH,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t   op;
        word_t word;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ_WAIT,
        ST_SRCH
    } state_t;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        word_t                front;
        word_t                rear;
        cnt_t                 count;
        logic                 is_empty;
        logic                 is_full;
        logic                 found;
        idx_t                 found_slot;
    } result_t;

    // zero selects the default size; anything above DEPTH saturates
    function automatic cnt_t clamp_cap(input logic [CFG_BITS-1:0] v);
        int c;
        c = (v == '0) ? CAP_DEFAULT : int'(v);
        if (c > DEPTH)
        begin
            c = DEPTH;
        end
        return cnt_t'(c);
    endfunction

    function automatic idx_t advance(input idx_t i, input cnt_t cap);
        cnt_t n;
        n = cnt_t'(i) + cnt_t'(1);
        return (n >= cap) ? '0 : n[IDX_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cqs_if.sv =====
// cqs_if: valid/ready channel interfaces for request and response words.
// Depends on cqs_pkg.
`default_nettype none

interface cqs_req_if import cqs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACT_BITS-1:0]        action;
    logic signed [WORD_BITS-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface cqs_rsp_if import cqs_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [STAT_BITS-1:0]        status;
    logic signed [WORD_BITS-1:0] front_value;
    logic signed [WORD_BITS-1:0] rear_value;
    logic [CNT_BITS-1:0]         count;
    logic                        is_empty;
    logic                        is_full;
    logic                        found;
    logic [IDX_BITS-1:0]         found_slot;

    modport source (output valid, output status, output front_value, output rear_value,
                    output count, output is_empty, output is_full, output found,
                    output found_slot, input ready);
    modport sink   (input valid, input status, input front_value, input rear_value,
                    input count, input is_empty, input is_full, input found,
                    input found_slot, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cqs_front.sv =====
// cqs_front: accepts request words, decodes the action and buffers commands in a
// two-entry queue for the back end. Depends on cqs_pkg, cqs_if.
`default_nettype none

module cqs_front import cqs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cqs_req_if.sink     req,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    cmd_t       dec;

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        dec.word = word_t'(req.value);
        case (req.action)
            ACT_ENQ:  dec.op = OP_ENQ;
            ACT_DEQ:  dec.op = OP_DEQ;
            ACT_SRCH: dec.op = OP_SRCH;
            default:  dec.op = OP_NOP;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cqs_back.sv =====
// cqs_back: executes queue commands against the slot memory and registers the response.
// Depends on cqs_pkg, cqs_if.
`default_nettype none

module cqs_back import cqs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    cqs_rsp_if.source           rsp
);

    word_t   mem [DEPTH];
    word_t   rd_data_reg;
    idx_t    rd_addr;
    idx_t    wr_addr;
    logic    mem_we;

    state_t  state_reg, state_next;
    cnt_t    cap_reg, cap_next;
    cnt_t    cap_m1;
    idx_t    head_reg, head_next;
    idx_t    tail_reg, tail_next;
    cnt_t    count_reg, count_next;
    word_t   front_reg, front_next;
    word_t   rear_reg, rear_next;
    word_t   key_reg, key_next;
    idx_t    cmp_idx_reg, cmp_idx_next;
    cnt_t    remain_reg, remain_next;
    result_t res_reg, res_next;
    logic    rsp_valid_reg, rsp_valid_next;

    logic                 slot_free;
    logic                 take;
    logic                 hit;
    logic                 emit;
    logic [STAT_BITS-1:0] stat;
    logic                 found;
    idx_t                 fslot;

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign take      = cmd_valid && slot_free;
    assign hit       = (rd_data_reg == key_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (cmd.op == OP_DEQ && count_reg > cnt_t'(1))
                    begin
                        state_next = ST_DEQ_WAIT;
                    end
                    else if (cmd.op == OP_SRCH && count_reg != '0)
                    begin
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_DEQ_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_SRCH:
            begin
                if (hit || remain_reg == cnt_t'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cap_next     = cap_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        front_next   = front_reg;
        rear_next    = rear_reg;
        key_next     = key_reg;
        cmp_idx_next = cmp_idx_reg;
        remain_next  = remain_reg;
        cmd_pop      = 1'b0;
        emit         = 1'b0;
        mem_we       = 1'b0;
        wr_addr      = tail_reg;
        rd_addr      = cmp_idx_reg;
        stat         = STAT_DONE;
        found        = 1'b0;
        fslot        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_ENQ:
                        begin
                            emit = 1'b1;
                            if (count_reg >= cap_reg)
                            begin
                                stat = STAT_FULL;
                            end
                            else
                            begin
                                tail_next  = advance(tail_reg, cap_reg);
                                mem_we     = 1'b1;
                                wr_addr    = tail_next;
                                count_next = count_reg + cnt_t'(1);
                                rear_next  = cmd.word;
                                if (count_reg == '0)
                                begin
                                    front_next = cmd.word;
                                end
                            end
                        end
                        OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                stat = STAT_EMPTY;
                                emit = 1'b1;
                            end
                            else
                            begin
                                head_next  = advance(head_reg, cap_reg);
                                count_next = count_reg - cnt_t'(1);
                                rd_addr    = head_next;
                                emit       = (count_reg == cnt_t'(1));
                            end
                        end
                        OP_SRCH:
                        begin
                            if (count_reg == '0)
                            begin
                                stat = STAT_EMPTY;
                                emit = 1'b1;
                            end
                            else
                            begin
                                key_next     = cmd.word;
                                cmp_idx_next = head_reg;
                                remain_next  = count_reg;
                                rd_addr      = head_reg;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEQ_WAIT:
            begin
                front_next = rd_data_reg;
                emit       = 1'b1;
            end
            ST_SRCH:
            begin
                if (hit)
                begin
                    found = 1'b1;
                    fslot = cmp_idx_reg;
                    emit  = 1'b1;
                end
                else if (remain_reg == cnt_t'(1))
                begin
                    emit = 1'b1;
                end
                else
                begin
                    cmp_idx_next = advance(cmp_idx_reg, cap_reg);
                    remain_next  = remain_reg - cnt_t'(1);
                    rd_addr      = cmp_idx_next;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // new capacity empties the queue
        cap_m1 = '0;
        if (cfg_we)
        begin
            cap_next   = clamp_cap(cfg_data);
            cap_m1     = cap_next - cnt_t'(1);
            head_next  = '0;
            tail_next  = cap_m1[IDX_BITS-1:0];
            count_next = '0;
        end

        res_next.status     = stat;
        res_next.front      = (count_next == '0) ? '0 : front_next;
        res_next.rear       = (count_next == '0) ? '0 : rear_next;
        res_next.count      = count_next;
        res_next.is_empty   = (count_next == '0);
        res_next.is_full    = (count_next == cap_next);
        res_next.found      = found;
        res_next.found_slot = fslot;

        rsp_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= idx_t'(CAP_RESET_INT - 1);
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg   <= front_next;
        rear_reg    <= rear_next;
        key_reg     <= key_next;
        cmp_idx_reg <= cmp_idx_next;
        remain_reg  <= remain_next;
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= cmd.word;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = res_reg.status;
    assign rsp.front_value = res_reg.front;
    assign rsp.rear_value  = res_reg.rear;
    assign rsp.count       = res_reg.count;
    assign rsp.is_empty    = res_reg.is_empty;
    assign rsp.is_full     = res_reg.is_full;
    assign rsp.found       = res_reg.found;
    assign rsp.found_slot  = res_reg.found_slot;

endmodule

`default_nettype wire

// ===== rtl/core/circular_queue_with_search.sv =====
// circular_queue_with_search: top level, front end plus back end.
// Depends on cqs_pkg, cqs_if, cqs_front, cqs_back.
//
// Usage:
//   req carries one word per action (enqueue, dequeue, search; code 3 is a no-op).
//   rsp returns exactly one word per request: status, front and rear values,
//   count, empty/full flags and, for a search, found and the physical slot.
//   cfg_we/cfg_data write the capacity (0 selects 100, above 128 saturates);
//   the write empties the queue and must only happen while the block is idle.
// Path from request accept to response valid:
//   enqueue, rejected actions, no-op: command queue register, then response register.
//   dequeue: as enqueue when it empties the queue, else the back end waits in ST_DEQ_WAIT for the slot memory read.
//   search: command queue register, then a scan in ST_SRCH that compares one slot per cycle
//   through the single memory read port until a hit or the last slot, then response register.
// Throughput: one word per cycle for enqueue and no-op while rsp is not stalled; a dequeue that
//   leaves the queue non-empty holds the back end for ST_DEQ_WAIT; a search holds it for its whole scan.
// A two-word command queue sits between front and back end; req.ready drops when it fills.
// Reset: capacity 100, queue empty, no response pending. Slot memory is not cleared.
// A stalled rsp holds its word; the back end takes no new command until it is taken.
`default_nettype none

module circular_queue_with_search import cqs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_data,
    cqs_req_if.sink             req,
    cqs_rsp_if.source           rsp
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    cqs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cqs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.is_empty == (rsp.count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.is_empty) |-> (rsp.front_value == '0 && rsp.rear_value == '0))
        else $error("front/rear not zero on empty queue");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_FULL) |-> rsp.is_full)
        else $error("full rejection while queue not full");

    a_slot_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.found_slot == '0))
        else $error("slot reported without a match");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for circular_queue_with_search.
// Queue mirror class predicts each response word; tasks drive requests and capacity writes.
// Depends on cqs_pkg, cqs_if and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
    import cqs_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    // Mirrors the queue state and keeps the response words still owed by the block.
    class queue_mirror;
        word_t   mem [DEPTH];
        idx_t    head;
        idx_t    tail;
        int      used;
        int      cap;
        result_t expected_rsp [$];
        int      errors;
        int      n_checked;
        int      n_found;
        int      n_full;
        int      n_empty;
        int      peak_used;

        function new();
            errors    = 0;
            n_checked = 0;
            n_found   = 0;
            n_full    = 0;
            n_empty   = 0;
            peak_used = 0;
            cap       = CAP_DEFAULT;
            head      = '0;
            tail      = idx_t'(cap - 1);
            used      = 0;
        endfunction

        function void set_capacity(input logic [CFG_BITS-1:0] v);
            cap = (v == 0) ? CAP_DEFAULT : int'(v);
            if (cap > DEPTH)
            begin
                cap = DEPTH;
            end
            head = '0;
            tail = idx_t'(cap - 1);
            used = 0;
        endfunction

        function idx_t next_slot(input idx_t i);
            if (int'(i) + 1 >= cap)
            begin
                return '0;
            end
            return i + 1'b1;
        endfunction

        function word_t word_at(input int k);
            idx_t p;
            p = head;
            repeat (k)
            begin
                p = next_slot(p);
            end
            return mem[p];
        endfunction

        function void note_request(input op_t op, input word_t w);
            result_t r;
            idx_t    p;
            r        = '0;
            r.status = STAT_DONE;
            case (op)
                OP_ENQ:
                begin
                    if (used >= cap)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        tail      = next_slot(tail);
                        mem[tail] = w;
                        used++;
                    end
                end
                OP_DEQ:
                begin
                    if (used == 0)
                    begin
                        r.status = STAT_EMPTY;
                    end
                    else
                    begin
                        head = next_slot(head);
                        used--;
                    end
                end
                OP_SRCH:
                begin
                    if (used == 0)
                    begin
                        r.status = STAT_EMPTY;
                    end
                    else
                    begin
                        p = head;
                        for (int k = 0; k < used; k++)
                        begin
                            if (!r.found && mem[p] == w)
                            begin
                                r.found      = 1'b1;
                                r.found_slot = p;
                            end
                            p = next_slot(p);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (used != 0)
            begin
                r.front = mem[head];
                r.rear  = mem[tail];
            end
            r.count    = cnt_t'(used);
            r.is_empty = (used == 0);
            r.is_full  = (used == cap);
            if (r.found)
            begin
                n_found++;
            end
            if (r.status == STAT_FULL)
            begin
                n_full++;
            end
            if (r.status == STAT_EMPTY)
            begin
                n_empty++;
            end
            if (used > peak_used)
            begin
                peak_used = used;
            end
            expected_rsp.push_back(r);
        endfunction

        function void check_field(input string name, input longint exp, input longint got);
            if (exp != got)
            begin
                $error("%s: expected %0d, got %0d", name, exp, got);
                errors++;
            end
        endfunction

        function void check_response(input result_t got);
            result_t exp;
            if (expected_rsp.size() == 0)
            begin
                $error("response word with nothing outstanding");
                errors++;
                return;
            end
            exp = expected_rsp.pop_front();
            n_checked++;
            check_field("status", exp.status, got.status);
            check_field("front_value", $signed(exp.front), $signed(got.front));
            check_field("rear_value", $signed(exp.rear), $signed(got.rear));
            check_field("count", exp.count, got.count);
            check_field("is_empty", exp.is_empty, got.is_empty);
            check_field("is_full", exp.is_full, got.is_full);
            check_field("found", exp.found, got.found);
            check_field("found_slot", exp.found_slot, got.found_slot);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_data;

    cqs_req_if req_ch ();
    cqs_rsp_if rsp_ch ();

    circular_queue_with_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    queue_mirror qm = new();

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_left     = 0;
    int n_sent        = 0;
    int n_caps        = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : rsp_monitor
        result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status     = rsp_ch.status;
            got.front      = rsp_ch.front_value;
            got.rear       = rsp_ch.rear_value;
            got.count      = rsp_ch.count;
            got.is_empty   = rsp_ch.is_empty;
            got.is_full    = rsp_ch.is_full;
            got.found      = rsp_ch.found;
            got.found_slot = rsp_ch.found_slot;
            qm.check_response(got);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Called at a falling edge; leaves valid high after acceptance.
    task automatic send_word(input op_t op, input word_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= op;
        req_ch.value  <= w;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        qm.note_request(op, w);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_BITS-1:0] v);
        req_ch.valid <= 1'b0;
        while (qm.expected_rsp.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        qm.set_capacity(v);
        n_caps++;
    endtask

    function automatic word_t pick_word();
        if ($urandom_range(99) < 35)
        begin
            case ($urandom_range(7))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'hffff_ffff;
                3: return 32'h0000_0000;
                4: return 32'h0000_0001;
                5: return 32'h5555_5555;
                6: return 32'haaaa_aaaa;
                default: return 32'h0000_002a;
            endcase
        end
        return $urandom;
    endfunction

    // Swings between filling and draining so both full and empty are reached.
    task automatic run_phase(input logic [CFG_BITS-1:0] cap_code, input int n_items,
                             input int srch_pct, input int src_pct, input int snk_pct,
                             input int hold);
        bit    filling;
        int    r;
        op_t   op;
        word_t w;
        write_capacity(cap_code);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        hold_left     = hold;
        filling       = 1'b1;
        repeat (n_items)
        begin
            if (qm.used == qm.cap)
            begin
                filling = 1'b0;
            end
            else if (qm.used == 0)
            begin
                filling = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 3)
            begin
                op = OP_NOP;
            end
            else if (r < 3 + srch_pct)
            begin
                op = OP_SRCH;
            end
            else
            begin
                op = ($urandom_range(99) < (filling ? 85 : 15)) ? OP_ENQ : OP_DEQ;
            end
            if (op == OP_SRCH && qm.used > 0 && $urandom_range(99) < 60)
            begin
                w = qm.word_at($urandom_range(qm.used - 1));
            end
            else
            begin
                w = pick_word();
            end
            send_word(op, w);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        req_ch.valid  = 1'b0;
        req_ch.action = OP_ENQ;
        req_ch.value  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset capacity: empty rejections, extremes, duplicate words
        send_word(OP_DEQ, 32'h0);
        send_word(OP_SRCH, 32'h0);
        send_word(OP_NOP, 32'hffff_ffff);
        send_word(OP_ENQ, 32'h7fff_ffff);
        send_word(OP_ENQ, 32'h8000_0000);
        send_word(OP_ENQ, 32'hffff_ffff);
        send_word(OP_ENQ, 32'h0);
        send_word(OP_ENQ, 32'h7fff_ffff);
        send_word(OP_SRCH, 32'h7fff_ffff);
        send_word(OP_SRCH, 32'h1234_5678);
        send_word(OP_NOP, 32'h0);
        send_word(OP_DEQ, 32'h0);
        send_word(OP_SRCH, 32'h7fff_ffff);
        send_word(OP_SRCH, 32'h0);

        // single slot
        write_capacity(8'd1);
        send_word(OP_ENQ, 32'h5);
        send_word(OP_ENQ, 32'h6);
        send_word(OP_SRCH, 32'h5);
        send_word(OP_DEQ, 32'h0);
        send_word(OP_DEQ, 32'h0);

        // two slots, tail wraps
        write_capacity(8'd2);
        send_word(OP_ENQ, 32'hdead_beef);
        send_word(OP_ENQ, 32'h0bad_cafe);
        send_word(OP_DEQ, 32'h0);
        send_word(OP_ENQ, 32'h8000_0001);
        send_word(OP_SRCH, 32'h8000_0001);

        run_phase(8'd0, 250, 15, 0, 0, 0);
        run_phase(8'd3, 110, 25, 54, 0, 0);
        run_phase(8'd255, 260, 8, 0, 54, HOLD_CYCLES);
        run_phase(8'd1, 70, 20, 35, 35, 0);
        run_phase(8'd128, 50, 20, 0, 0, 0);
        run_phase(8'd2, 50, 20, 54, 0, 0);
        run_phase(8'($urandom_range(4, 127)), 50, 20, 0, 54, 0);
        run_phase(8'($urandom_range(1, 255)), 50, 20, 35, 35, 0);
        run_phase(8'd7, 50, 20, 0, 0, 0);

        req_ch.valid <= 1'b0;
        while (qm.expected_rsp.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        $display("Sent %0d request words across %0d capacity writes; %0d responses checked.",
                 n_sent, n_caps, qm.n_checked);
        $display("Peak fill %0d, searches hit %0d, full rejects %0d, empty rejects %0d.",
                 qm.peak_used, qm.n_found, qm.n_full, qm.n_empty);
        if (qm.errors == 0 && qm.expected_rsp.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
